### src/owrm_pkg.sv
package owrm_pkg;

    localparam int KEY_COUNT = 3;
    localparam logic [7:0] KEY_MASK = 8'((1 << KEY_COUNT) - 1);

    localparam logic [7:0] CRC_SEED = 8'hAC;
    localparam logic [7:0] CRC_POLY = 8'h07;

    localparam logic [7:0] REQ_KEY_CODE   = 8'h30;
    localparam logic [7:0] REQ_TOUCH_CODE = 8'h40;
    localparam logic [7:0] REQ_INFO_CODE  = 8'h60;

    localparam logic [5:0] SEND_BITS  = 6'd16;
    localparam logic [5:0] REPLY_BITS = 6'd32;
    localparam logic [5:0] WAIT_TICKS = 6'd2;
    localparam logic [5:0] STOP_TICKS = 6'd2;
    localparam logic [5:0] CRC_BYTES_END = 6'd8;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_SEND  = 3'd2,
        PH_WAIT  = 3'd3,
        PH_REPLY = 3'd4,
        PH_STOP  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        KIND_NONE      = 3'd0,
        KIND_KEY       = 3'd1,
        KIND_TOUCH     = 3'd2,
        KIND_INFO      = 3'd3,
        KIND_BACKLIGHT = 3'd4
    } kind_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] request_code;
        logic       line_in;
    } item_t;

    typedef struct packed {
        logic       line_out;
        logic       line_is_output;
        logic       busy_res;
        logic       response_done;
        logic       crc_ok;
        logic [2:0] response_kind;
        logic [7:0] reply_first;
        logic [7:0] reply_second;
        logic [7:0] reply_third;
        logic [2:0] key_changed;
        logic [2:0] key_pressed;
    } result_t;

    function automatic logic [7:0] crc_bit(input logic [7:0] crc, input logic din);
        logic fb;
        fb = crc[7] ^ din;
        return {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    endfunction

    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] v);
        logic [7:0] c;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            c = crc_bit(c, v[i]);
        end
        return c;
    endfunction

endpackage

### src/one_wire_request_response_master.sv
// Single-wire request/response master with CRC-8 (poly 0x07, seed 0xAC) on
// both the request and the reply. Each input item is either a start (tuser=1,
// taken only while idle, otherwise ignored) or one bit-time tick carrying the
// sampled wire level; every item yields exactly one result item with the
// wire drive, session status and, on the tick of the 32nd reply bit, the
// three reply bytes, CRC status, reply class and key change bits. An item
// enters an input register, is processed combinationally against the session
// state and lands in a result register: one item per clock sustained while the
// result is taken (m_tready). A stalled result register blocks at most one
// further item, held in the input register.
module one_wire_request_response_master (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] request_code, [8] line_in, [15:9] zero
    input  logic [15:0] s_tdata,
    // [0] mode
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] line_out, [1] line_is_output, [2] busy_res, [3] response_done,
    // [4] crc_ok, [7:5] response_kind, [15:8] reply_first,
    // [23:16] reply_second, [31:24] reply_third, [34:32] key_changed,
    // [37:35] key_pressed, [39:38] zero
    output logic [39:0] m_tdata
);

    logic               in_valid_reg;
    owrm_pkg::item_t    in_item_reg;
    logic               out_valid_reg;
    owrm_pkg::result_t  out_res_reg;
    owrm_pkg::result_t  step_res;
    logic               advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.mode         <= s_tuser;
            in_item_reg.request_code <= s_tdata[7:0];
            in_item_reg.line_in      <= s_tdata[8];
        end
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    owrm_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .result  (step_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_res_reg.key_pressed,
                       out_res_reg.key_changed,
                       out_res_reg.reply_third,
                       out_res_reg.reply_second,
                       out_res_reg.reply_first,
                       out_res_reg.response_kind,
                       out_res_reg.crc_ok,
                       out_res_reg.response_done,
                       out_res_reg.busy_res,
                       out_res_reg.line_is_output,
                       out_res_reg.line_out};

endmodule

### src/owrm_core.sv
module owrm_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  owrm_pkg::item_t   item,
    output owrm_pkg::result_t result
);

    owrm_pkg::phase_t phase_reg, phase_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] shift_reg, shift_next;
    logic [7:0]  pending_reg, pending_next;
    logic [2:0]  keys_reg, keys_next;
    logic        level_reg, level_next;
    logic        enable_reg, enable_next;
    logic [7:0]  crc_reg, crc_next;

    logic [5:0]  cnt_dec;
    logic [31:0] shift_in;
    logic [2:0]  key_now;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= owrm_pkg::PH_IDLE;
            cnt_reg     <= '0;
            shift_reg   <= '0;
            pending_reg <= '0;
            keys_reg    <= '0;
            level_reg   <= 1'b1;
            enable_reg  <= 1'b1;
            crc_reg     <= '0;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            shift_reg   <= shift_next;
            pending_reg <= pending_next;
            keys_reg    <= keys_next;
            level_reg   <= level_next;
            enable_reg  <= enable_next;
            crc_reg     <= crc_next;
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        shift_next   = shift_reg;
        pending_next = pending_reg;
        keys_next    = keys_reg;
        level_next   = level_reg;
        enable_next  = enable_reg;
        crc_next     = crc_reg;
        cnt_dec      = cnt_reg - 6'd1;
        shift_in     = {shift_reg[30:0], item.line_in};
        key_now      = 3'(shift_in[15:8] & owrm_pkg::KEY_MASK);

        result = '0;

        if (item.mode) begin
            if (phase_reg == owrm_pkg::PH_IDLE) begin
                pending_next = item.request_code;
                shift_next   = {item.request_code,
                                owrm_pkg::crc_byte(owrm_pkg::CRC_SEED, item.request_code),
                                16'h0000};
                cnt_next     = 6'd1;
                phase_next   = owrm_pkg::PH_START;
                enable_next  = 1'b1;
                level_next   = 1'b0;
            end
        end else if (phase_reg != owrm_pkg::PH_IDLE) begin
            cnt_next = cnt_dec;
            unique case (phase_reg)
                owrm_pkg::PH_START: begin
                    if (cnt_dec == '0) begin
                        cnt_next   = owrm_pkg::SEND_BITS;
                        phase_next = owrm_pkg::PH_SEND;
                    end
                end
                owrm_pkg::PH_SEND: begin
                    level_next = shift_reg[31];
                    shift_next = {shift_reg[30:0], 1'b0};
                    if (cnt_dec == '0) begin
                        cnt_next   = owrm_pkg::WAIT_TICKS;
                        phase_next = owrm_pkg::PH_WAIT;
                    end
                end
                owrm_pkg::PH_WAIT: begin
                    if (cnt_dec == '0) begin
                        cnt_next   = owrm_pkg::REPLY_BITS;
                        shift_next = '0;
                        crc_next   = owrm_pkg::CRC_SEED;
                        phase_next = owrm_pkg::PH_REPLY;
                    end else if (cnt_dec == 6'd1) begin
                        enable_next = 1'b0;
                        level_next  = 1'b1;
                    end
                end
                owrm_pkg::PH_REPLY: begin
                    shift_next = shift_in;
                    if (cnt_dec >= owrm_pkg::CRC_BYTES_END) begin
                        crc_next = owrm_pkg::crc_bit(crc_reg, item.line_in);
                    end
                    if (cnt_dec == '0) begin
                        cnt_next     = owrm_pkg::STOP_TICKS;
                        phase_next   = owrm_pkg::PH_STOP;
                        level_next   = 1'b1;
                        enable_next  = 1'b1;
                        result.response_done = 1'b1;
                        result.reply_first   = shift_in[31:24];
                        result.reply_second  = shift_in[23:16];
                        result.reply_third   = shift_in[15:8];
                        if (crc_reg == shift_in[7:0]) begin
                            result.crc_ok = 1'b1;
                            unique case (pending_reg)
                                owrm_pkg::REQ_KEY_CODE: begin
                                    result.response_kind = owrm_pkg::KIND_KEY;
                                    result.key_changed   = keys_reg ^ key_now;
                                    keys_next            = key_now;
                                end
                                owrm_pkg::REQ_TOUCH_CODE: begin
                                    result.response_kind = owrm_pkg::KIND_TOUCH;
                                end
                                owrm_pkg::REQ_INFO_CODE: begin
                                    result.response_kind = owrm_pkg::KIND_INFO;
                                end
                                default: begin
                                    result.response_kind = owrm_pkg::KIND_BACKLIGHT;
                                end
                            endcase
                        end
                    end
                end
                owrm_pkg::PH_STOP: begin
                    if (cnt_dec == '0) begin
                        phase_next = owrm_pkg::PH_IDLE;
                    end
                end
                default: begin
                    phase_next = owrm_pkg::PH_IDLE;
                end
            endcase
        end

        result.line_out       = level_next;
        result.line_is_output = enable_next;
        result.busy_res       = (phase_next != owrm_pkg::PH_IDLE);
        result.key_pressed    = keys_next;
    end

endmodule

### src/owrm_checker.sv
module owrm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_done_drives: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[2] && m_tdata[1] && m_tdata[0])
        else $error("reply end without busy, driven high line");

    a_kind_needs_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[7:5] != owrm_pkg::KIND_NONE) |-> m_tdata[4] && m_tdata[3])
        else $error("reply class without good crc");

    a_change_needs_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[4] |->
            (m_tdata[34:32] == 3'd0) && (m_tdata[7:5] == owrm_pkg::KIND_NONE))
        else $error("key change or class on bad reply");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind one_wire_request_response_master owrm_checker u_owrm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
